// ===== design/siq_pkg.sv =====
package siq_pkg;

  // Fixed field widths
  localparam int CH_W       = 6;
  localparam int THRESH_W   = 10;
  localparam int DEADBAND_W = 10;
  localparam int MASK_W     = 64;
  localparam int HELD_OUT_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = MASK_W;

  // Defaults for the top-level parameters
  localparam int NUM_CHANNELS_DEF = 64;
  localparam int SAMPLE_BITS_DEF  = 10;

  // Register reset values
  localparam logic [MASK_W-1:0]     MASK_RESET     = 64'd258100690956;
  localparam logic [THRESH_W-1:0]   THRESH_RESET   = 10'd512;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 10'd10;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUTTON_MASK  = 2'd0,
    REG_PRESS_THRESH = 2'd1,
    REG_POT_DEADBAND = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [MASK_W-1:0]     button_mask;
    logic [THRESH_W-1:0]   press_threshold;
    logic [DEADBAND_W-1:0] pot_deadband;
  } siq_cfg_t;

endpackage

// ===== design/scanned_input_qualifier_top.sv =====
// Channel    | Dir | Handshake        | Payload
// s_*        | in  | s_tvalid/tready  | channel, sample
// m_*        | out | m_tvalid/tready  | out_channel, held_value, toggle_state,
//            |     |                  | press_edge, value_changed
// cfg_*      | in  | cfg_we           | cfg_index, cfg_data (no read-back)
//
// One transaction per cycle sustained while m_tready stays high.
// Accepting an input issues the state memory read and loads stage 1; stage 1
// qualifies, writes back and loads the output register. A write-back to the
// channel being read is forwarded from the memory's last-write register.
// Reset clears the per-entry written flags at once; unwritten entries read as
// held -1, toggle 0. A stalled output blocks s_tready only once stage 1 is full.
module scanned_input_qualifier_top #(
  parameter int NUM_CHANNELS = siq_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = siq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // tdata: [5:0] channel, [6 +: SAMPLE_BITS] sample, rest zero
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((siq_pkg::CH_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // tdata: [5:0] out_channel, [16:6] held_value, [17] toggle_state,
  //        [18] press_edge, [19] value_changed, [23:20] zero
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [23:0]                         m_tdata,
  input  logic                                cfg_we,
  input  logic [siq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [siq_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import siq_pkg::*;

  localparam int AW     = $clog2(NUM_CHANNELS);
  localparam int HELD_W = SAMPLE_BITS + 1;
  localparam int ENT_W  = HELD_W + 1;          // {toggle, held}
  localparam int OUT_W  = CH_W + HELD_OUT_W + 3;

  siq_cfg_t cfg;

  siq_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input unpack
  logic [CH_W-1:0]        in_ch;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   in_fire;
  assign in_ch     = s_tdata[CH_W-1:0];
  assign in_sample = s_tdata[CH_W +: SAMPLE_BITS];

  // Stage 1: item whose state read is in flight / returned
  logic                   s1_valid;
  logic [CH_W-1:0]        s1_ch;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic                   advance;

  // Output register
  logic                   out_valid;
  logic [OUT_W-1:0]       out_data;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign in_fire  = s_tvalid && s_tready;

  // State memory
  logic [ENT_W-1:0] rd_data;
  logic             rd_written;
  logic             wr_en;
  logic [ENT_W-1:0] wr_data;

  siq_state_mem #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .DATA_W       (ENT_W)
  ) u_mem (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (in_fire),
    .rd_addr    (in_ch[AW-1:0]),
    .rd_data    (rd_data),
    .rd_written (rd_written),
    .wr_en      (wr_en),
    .wr_addr    (s1_ch[AW-1:0]),
    .wr_data    (wr_data)
  );

  // Previous state; never-written entries read as held -1, toggle 0
  logic signed [HELD_W-1:0] prev_held;
  logic                     prev_toggle;
  assign prev_held   = rd_written ? $signed(rd_data[HELD_W-1:0]) : '1;
  assign prev_toggle = rd_written ? rd_data[HELD_W] : 1'b0;

  logic in_range;
  assign in_range = {1'b0, s1_ch} < (CH_W + 1)'(NUM_CHANNELS);

  logic signed [HELD_W-1:0] next_held;
  logic                     next_toggle;
  logic                     edge_q;
  logic                     changed;

  siq_qualify #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_qual (
    .cfg           (cfg),
    .is_button     (cfg.button_mask[s1_ch]),
    .sample        (s1_sample),
    .prev_held     (prev_held),
    .prev_toggle   (prev_toggle),
    .next_held     (next_held),
    .next_toggle   (next_toggle),
    .press_edge    (edge_q),
    .value_changed (changed)
  );

  assign wr_en   = s1_valid && advance && in_range;
  assign wr_data = {next_toggle, next_held};

  // held_value is the stored value sign-extended or truncated to 11 bits
  logic [HELD_W+HELD_OUT_W-1:0] held_ext;
  logic [HELD_OUT_W-1:0]        held_out;
  assign held_ext = {{HELD_OUT_W{next_held[HELD_W-1]}}, next_held};
  assign held_out = held_ext[HELD_OUT_W-1:0];

  logic [OUT_W-1:0] result_next;
  always_comb begin
    if (in_range) begin
      result_next = {changed, edge_q, next_toggle, held_out, s1_ch};
    end else begin
      result_next = {1'b0, 1'b0, 1'b0, {HELD_OUT_W{1'b1}}, s1_ch};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch     <= in_ch;
      s1_sample <= in_sample;
    end
    if (advance && s1_valid) begin
      out_data <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(24 - OUT_W)'(0), out_data};

endmodule

// ===== design/siq_cfg_regs.sv =====
module siq_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [siq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [siq_pkg::CFG_DATA_W-1:0] cfg_data,
  output siq_pkg::siq_cfg_t              cfg
);
  import siq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_mask     <= MASK_RESET;
      cfg.press_threshold <= THRESH_RESET;
      cfg.pot_deadband    <= DEADBAND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUTTON_MASK:  cfg.button_mask     <= cfg_data[MASK_W-1:0];
        REG_PRESS_THRESH: cfg.press_threshold <= cfg_data[THRESH_W-1:0];
        REG_POT_DEADBAND: cfg.pot_deadband    <= cfg_data[DEADBAND_W-1:0];
        default: ;  // unused index: write dropped
      endcase
    end
  end

endmodule

// ===== design/siq_state_mem.sv =====
module siq_state_mem #(
  parameter int NUM_CHANNELS = siq_pkg::NUM_CHANNELS_DEF,
  parameter int DATA_W       = siq_pkg::SAMPLE_BITS_DEF + 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [$clog2(NUM_CHANNELS)-1:0] rd_addr,
  output logic [DATA_W-1:0]               rd_data,
  output logic                            rd_written,
  input  logic                            wr_en,
  input  logic [$clog2(NUM_CHANNELS)-1:0] wr_addr,
  input  logic [DATA_W-1:0]               wr_data
);
  import siq_pkg::*;

  localparam int AW = $clog2(NUM_CHANNELS);

  logic [DATA_W-1:0]       mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] written;

  logic [DATA_W-1:0] rd_q;
  logic              rd_written_q;
  logic [AW-1:0]     rd_addr_q;

  // last write, forwarded when it hit the entry just read
  logic              lw_valid;
  logic [AW-1:0]     lw_addr;
  logic [DATA_W-1:0] lw_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (wr_en) begin
      lw_addr <= wr_addr;
      lw_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written      <= '0;
      rd_written_q <= 1'b0;
      lw_valid     <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
        lw_valid         <= 1'b1;
      end
      if (rd_en) begin
        rd_written_q <= written[rd_addr];
      end
    end
  end

  logic fwd_hit;
  assign fwd_hit    = lw_valid && (lw_addr == rd_addr_q);
  assign rd_data    = fwd_hit ? lw_data : rd_q;
  assign rd_written = fwd_hit || rd_written_q;

endmodule

// ===== design/siq_qualify.sv =====
module siq_qualify #(
  parameter int SAMPLE_BITS = siq_pkg::SAMPLE_BITS_DEF
) (
  input  siq_pkg::siq_cfg_t               cfg,
  input  logic                            is_button,
  input  logic [SAMPLE_BITS-1:0]          sample,
  input  logic signed [SAMPLE_BITS:0]     prev_held,
  input  logic                            prev_toggle,
  output logic signed [SAMPLE_BITS:0]     next_held,
  output logic                            next_toggle,
  output logic                            press_edge,
  output logic                            value_changed
);
  import siq_pkg::*;

  localparam int HELD_W  = SAMPLE_BITS + 1;
  localparam int DIFF_W  = SAMPLE_BITS + 2;
  localparam int PCMP_W  = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
  localparam int DCMP_W  = (HELD_W > DEADBAND_W) ? HELD_W : DEADBAND_W;

  logic                     pressed;
  logic signed [DIFF_W-1:0] diff;
  logic [HELD_W-1:0]        mag;
  logic                     outside;
  logic signed [HELD_W-1:0] btn_level;

  assign pressed   = PCMP_W'(sample) > PCMP_W'(cfg.press_threshold);
  assign btn_level = pressed ? HELD_W'(1) : '0;

  // |sample - held|, held may be -1
  assign diff    = $signed({2'b00, sample}) - $signed({prev_held[HELD_W-1], prev_held});
  assign mag     = diff[DIFF_W-1] ? HELD_W'(-diff) : diff[HELD_W-1:0];
  assign outside = DCMP_W'(mag) > DCMP_W'(cfg.pot_deadband);

  always_comb begin
    next_held     = prev_held;
    next_toggle   = prev_toggle;
    press_edge    = 1'b0;
    value_changed = 1'b0;
    if (is_button) begin
      if (pressed && (prev_held == '0)) begin
        next_toggle = ~prev_toggle;
        press_edge  = 1'b1;
      end
      next_held     = btn_level;
      value_changed = (btn_level != prev_held);
    end else if (outside) begin
      next_held     = $signed({1'b0, sample});
      value_changed = 1'b1;
    end
  end

endmodule
